FILE: hw/rtl/packed_pattern_cell_decoder_defines.svh
// assertion macros used by the decoder core
`ifndef PACKED_PATTERN_CELL_DECODER_DEFINES_SVH
`define PACKED_PATTERN_CELL_DECODER_DEFINES_SVH

// property checked on every rising edge outside reset
`define PPCD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define PPCD_ASSERT_NEXT(name, clk, rst_n, cond, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ppcd_pkg.sv
package ppcd_pkg;

    // pattern geometry
    localparam int ROWS      = 64;
    localparam int ROW_W     = $clog2(ROWS + 1);
    localparam int ROW_IDX_W = 6;
    localparam int LEN_W     = 16;
    localparam int BYTE_CNT_W = LEN_W + 1;

    // input item kinds
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // note kinds
    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_NOTE  = 2'd1;
    localparam logic [1:0] KIND_CUT   = 2'd2;

    // special note bytes and limits
    localparam logic [7:0] NOTE_EMPTY_BYTE = 8'd255;
    localparam logic [7:0] NOTE_CUT_BYTE   = 8'd254;
    localparam logic [7:0] VOL_MAX         = 8'd64;

    // flag byte bits
    localparam int FLAG_NOTE_BIT = 5;
    localparam int FLAG_VOL_BIT  = 6;
    localparam int FLAG_CMD_BIT  = 7;

    typedef struct packed {
        logic             mode;
        logic [LEN_W-1:0] packed_length;
        logic [7:0]       data_byte;
    } t_item;

    typedef struct packed {
        logic                 cell_valid;
        logic [4:0]           channel;
        logic [ROW_IDX_W-1:0] row_index;
        logic [1:0]           note_kind;
        logic [7:0]           note_value;
        logic signed [8:0]    instrument;
        logic                 has_volume;
        logic [6:0]           volume;
        logic                 has_command;
        logic signed [8:0]    command;
        logic [7:0]           parameter_res;
        logic                 pattern_done;
    } t_cell;

endpackage

FILE: hw/rtl/ppcd_in_reg.sv
module ppcd_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ppcd_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_advance,
    output logic           o_valid,
    output ppcd_pkg::t_item o_item
);
    import ppcd_pkg::*;

    logic  r_valid;
    t_item r_item;

    // register takes a new item when empty or when its item moves on
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload holds no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hw/rtl/ppcd_core.sv
`include "packed_pattern_cell_decoder_defines.svh"

module ppcd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  ppcd_pkg::t_item i_item,
    output logic            o_res_valid,
    output ppcd_pkg::t_cell o_res
);
    import ppcd_pkg::*;

    // parser phases
    localparam logic [2:0] PH_FLAG  = 3'd0;
    localparam logic [2:0] PH_NOTE  = 3'd1;
    localparam logic [2:0] PH_INSTR = 3'd2;
    localparam logic [2:0] PH_VOL   = 3'd3;
    localparam logic [2:0] PH_CMD   = 3'd4;
    localparam logic [2:0] PH_PARAM = 3'd5;

    logic [2:0]            r_phase,    n_phase;
    logic [7:0]            r_flags,    n_flags;
    logic [ROW_W-1:0]      r_row,      n_row;
    logic [BYTE_CNT_W-1:0] r_bytes,    n_bytes;
    logic [LEN_W-1:0]      r_limit,    n_limit;
    logic                  r_finished, n_finished;
    logic [1:0]            r_kind,     n_kind;
    logic [7:0]            r_note,     n_note;
    logic [8:0]            r_instr,    n_instr;
    logic [6:0]            r_vol,      n_vol;
    logic [8:0]            r_cmd,      n_cmd;
    logic [7:0]            r_param,    n_param;

    logic [7:0]            b;
    logic [7:0]            note_calc;
    logic [ROW_W-1:0]      row_inc;
    logic [BYTE_CNT_W-1:0] bytes_inc;
    logic                  emit;
    logic                  done_cell;
    logic                  done_row;

    // next field to expect after a given phase, from the flag byte
    function automatic logic [2:0] next_phase(input logic [2:0] after,
                                              input logic [7:0] flags);
        logic [2:0] ph;
        ph = PH_FLAG;
        if (after < PH_NOTE && flags[FLAG_NOTE_BIT]) begin
            ph = PH_NOTE;
        end else if (after < PH_VOL && flags[FLAG_VOL_BIT]) begin
            ph = PH_VOL;
        end else if (after < PH_CMD && flags[FLAG_CMD_BIT]) begin
            ph = PH_CMD;
        end
        return ph;
    endfunction

    assign b = i_item.data_byte;

    // octave * 12 + semitone, times twelve as two shifts
    assign note_calc = ({4'd0, b[7:4]} << 3) + ({4'd0, b[7:4]} << 2) + {4'd0, b[3:0]};

    // counters as they stand once this byte is taken
    assign row_inc   = r_row + 1'b1;
    assign bytes_inc = r_bytes + 1'b1;

    // end-of-pattern tests use the byte count including this byte
    assign done_cell = (r_row >= ROW_W'(ROWS))
                    || (bytes_inc > {1'b0, r_limit});
    assign done_row  = (row_inc >= ROW_W'(ROWS))
                    || (bytes_inc > {1'b0, r_limit});

    // per-byte decode and state update
    always_comb begin
        n_phase    = r_phase;
        n_flags    = r_flags;
        n_row      = r_row;
        n_bytes    = r_bytes;
        n_limit    = r_limit;
        n_finished = r_finished;
        n_kind     = r_kind;
        n_note     = r_note;
        n_instr    = r_instr;
        n_vol      = r_vol;
        n_cmd      = r_cmd;
        n_param    = r_param;
        emit       = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_step) begin
            if (i_item.mode == MODE_START) begin
                n_limit    = i_item.packed_length;
                n_row      = '0;
                n_bytes    = '0;
                n_phase    = PH_FLAG;
                n_flags    = '0;
                n_kind     = KIND_EMPTY;
                n_note     = '0;
                n_instr    = '1;
                n_vol      = '0;
                n_cmd      = '1;
                n_param    = '0;
                n_finished = 1'b0;
            end else if (!r_finished) begin
                n_bytes = bytes_inc;
                case (r_phase)
                    PH_FLAG: begin
                        if (b == 8'd0) begin
                            n_row = row_inc;
                            if (done_row) begin
                                n_finished         = 1'b1;
                                o_res_valid        = 1'b1;
                                o_res.pattern_done = 1'b1;
                            end
                        end else begin
                            n_flags = b;
                            n_kind  = KIND_EMPTY;
                            n_note  = '0;
                            n_instr = '1;
                            n_vol   = '0;
                            n_cmd   = '1;
                            n_param = '0;
                            n_phase = next_phase(PH_FLAG, b);
                            emit    = (n_phase == PH_FLAG);
                        end
                    end
                    PH_NOTE: begin
                        if (b == NOTE_EMPTY_BYTE) begin
                            n_kind = KIND_EMPTY;
                            n_note = '0;
                        end else if (b == NOTE_CUT_BYTE) begin
                            n_kind = KIND_CUT;
                            n_note = '0;
                        end else begin
                            n_kind = KIND_NOTE;
                            n_note = note_calc;
                        end
                        n_phase = PH_INSTR;
                    end
                    PH_INSTR: begin
                        n_instr = {1'b0, b} - 9'd1;
                        n_phase = next_phase(PH_INSTR, r_flags);
                        emit    = (n_phase == PH_FLAG);
                    end
                    PH_VOL: begin
                        n_vol   = (b > VOL_MAX) ? VOL_MAX[6:0] : b[6:0];
                        n_phase = next_phase(PH_VOL, r_flags);
                        emit    = (n_phase == PH_FLAG);
                    end
                    PH_CMD: begin
                        n_cmd   = {1'b0, b} - 9'd1;
                        n_phase = PH_PARAM;
                    end
                    default: begin
                        n_param = b;
                        n_phase = PH_FLAG;
                        emit    = 1'b1;
                    end
                endcase

                // finished cell goes out with its row
                if (emit) begin
                    n_finished          = done_cell;
                    o_res_valid         = 1'b1;
                    o_res.cell_valid    = 1'b1;
                    o_res.channel       = n_flags[4:0];
                    o_res.row_index     = ROW_IDX_W'(r_row);
                    o_res.note_kind     = n_kind;
                    o_res.note_value    = n_note;
                    o_res.instrument    = n_instr;
                    o_res.has_volume    = n_flags[FLAG_VOL_BIT];
                    o_res.volume        = n_vol;
                    o_res.has_command   = n_flags[FLAG_CMD_BIT];
                    o_res.command       = n_cmd;
                    o_res.parameter_res = n_param;
                    o_res.pattern_done  = done_cell;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FLAG;
            r_flags    <= '0;
            r_row      <= '0;
            r_bytes    <= '0;
            r_limit    <= '0;
            r_finished <= 1'b1;
            r_kind     <= KIND_EMPTY;
            r_note     <= '0;
            r_instr    <= '1;
            r_vol      <= '0;
            r_cmd      <= '1;
            r_param    <= '0;
        end else begin
            r_phase    <= n_phase;
            r_flags    <= n_flags;
            r_row      <= n_row;
            r_bytes    <= n_bytes;
            r_limit    <= n_limit;
            r_finished <= n_finished;
            r_kind     <= n_kind;
            r_note     <= n_note;
            r_instr    <= n_instr;
            r_vol      <= n_vol;
            r_cmd      <= n_cmd;
            r_param    <= n_param;
        end
    end

    // checks
    `PPCD_ASSERT(a_row_bound, i_clk, i_rst_n,
        r_row <= ROW_W'(ROWS), "row count past end")
    `PPCD_ASSERT(a_quiet_when_done, i_clk, i_rst_n,
        !(r_finished && o_res_valid), "result after end")
    `PPCD_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n,
        i_step && i_item.mode == MODE_START,
        r_phase == PH_FLAG && !r_finished && r_row == '0,
        "start did not restart decoding")
    `PPCD_ASSERT_NEXT(a_done_sticks, i_clk, i_rst_n,
        o_res_valid && o_res.pattern_done, r_finished, "end of pattern not held")
    `PPCD_ASSERT(a_emit_between_cells, i_clk, i_rst_n,
        !(o_res_valid && n_phase != PH_FLAG), "result with cell still open")

endmodule

FILE: hw/rtl/packed_pattern_cell_decoder.sv
// Packed pattern cell decoder: takes one packed pattern byte (or one start
// item carrying the packed length) per clock and returns at most one decoded
// note cell or end-of-pattern marker per byte. An accepted item passes the
// input register, then the result register. Throughput is one item every
// cycle while the result side accepts, set by the parser state update in the
// decode core; a stalled result side holds the input side through tready.
// After reset the decoder ignores data bytes until a start item arrives, and
// again once a pattern has ended (row limit reached or length exceeded).
module packed_pattern_cell_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // packed_length[15:0], data_byte[23:16]
    input  logic        i_s_tuser,   // mode
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // channel, row_index, note_kind, note_value,
                                     // instrument, has_volume, volume,
                                     // has_command, command, parameter_res
    output logic        o_m_tuser,   // cell_valid
    output logic        o_m_tlast    // pattern_done
);
    import ppcd_pkg::*;

    t_item in_item;
    t_item q_item;
    logic  q_valid;
    logic  out_free;
    logic  step;
    logic  res_valid;
    t_cell res;
    logic  r_out_valid;
    t_cell r_out;

    assign in_item.mode          = i_s_tuser;
    assign in_item.packed_length = i_s_tdata[15:0];
    assign in_item.data_byte     = i_s_tdata[23:16];

    // result register can take a value when empty or being drained
    assign out_free = !r_out_valid || i_m_tready;
    assign step     = q_valid && out_free;

    ppcd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_item    (in_item),
        .o_ready   (o_s_tready),
        .i_advance (out_free),
        .o_valid   (q_valid),
        .o_item    (q_item)
    );

    ppcd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (q_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && step && res_valid) begin
            r_out <= res;
        end
    end

    // pack the result transfer
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.cell_valid;
    assign o_m_tlast  = r_out.pattern_done;
    assign o_m_tdata  = {r_out.parameter_res, r_out.command, r_out.has_command,
                         r_out.volume, r_out.has_volume, r_out.instrument,
                         r_out.note_value, r_out.note_kind, r_out.row_index,
                         r_out.channel};

endmodule
